// ===== src/srq_pkg.sv =====
package srq_pkg;

  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned TrackBitsDefault = 16;

  // Action codes carried in the request
  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] track;
    logic [15:0] head_position;
  } srq_req_t;

  typedef struct packed {
    logic [15:0] removed_track;
    logic        removed_valid;
    logic        underflow;
    logic        dropped_full;
    logic        is_empty;
    logic [4:0]  entry_count;
  } srq_rsp_t;

  // Operation applied to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } srq_ctl_t;

endpackage

// ===== src/sstf_request_queue.sv =====
// Shortest-seek-time-first request queue.
//
// Request channel: a transfer happens at a rising edge with start_i high and
// busy_o low. req_i.action selects insert (track with current head position)
// or remove (pop the entry nearest to the head at its insert time).
// The seek distance |track - head_position| is fixed at insert and kept with
// the entry; entries stay sorted by ascending distance in a chain of DEPTH
// compare-and-shift cells, a newer entry ahead of older ones of equal distance.
//
// Result channel: every request yields exactly one result, shown on rsp_o for
// one cycle with rsp_valid_o high, the cycle after the request transfer.
// The receiver cannot stall; the result must be taken in that cycle.
//
// Throughput: one request per cycle while busy_o is low. Each cell compares its
// stored distance with the new one and moves by one place, so insert and pop
// both update the whole chain at the edge of the transfer.
//
// Reset: the entry count clears, so the queue is empty; busy_o is high for
// the first cycle after reset and low from then on. Cell contents are not
// cleared; cells beyond the entry count never reach a result.
module sstf_request_queue
  import srq_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned TRACK_BITS = TrackBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  srq_req_t req_i,
  output logic     busy_o,
  output logic     rsp_valid_o,
  output srq_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                  busy_q;
  logic                  accept;
  logic [CntW-1:0]       count_q, count_d;
  logic                  full, empty;
  logic [TRACK_BITS-1:0] new_trk, new_hp, new_dist;
  srq_ctl_t              ctl;
  srq_rsp_t              rsp_q, rsp_d;
  logic                  rsp_valid_q;

  logic [DEPTH-1:0]      ge;
  logic [TRACK_BITS-1:0] trk       [DEPTH];
  logic [TRACK_BITS-1:0] seek_dist [DEPTH];

  assign accept = start_i && !busy_q;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Take track and head in the low TRACK_BITS bits.
  assign new_trk  = TRACK_BITS'(req_i.track);
  assign new_hp   = TRACK_BITS'(req_i.head_position);
  assign new_dist = (new_trk >= new_hp) ? (new_trk - new_hp) : (new_hp - new_trk);

  // Drop inserts into a full queue and pops from an empty one.
  assign ctl.ins = accept && (req_i.action == ActInsert) && !full;
  assign ctl.rem = accept && (req_i.action == ActRemove) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  occ;
    logic                  left_ge;
    logic [TRACK_BITS-1:0] left_trk, left_dist, right_trk, right_dist;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_ge   = 1'b0;
      assign left_trk  = '0;
      assign left_dist = '0;
    end else begin : g_body
      assign left_ge   = ge[i-1];
      assign left_trk  = trk[i-1];
      assign left_dist = seek_dist[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_trk  = '0;
      assign right_dist = '0;
    end else begin : g_mid
      assign right_trk  = trk[i+1];
      assign right_dist = seek_dist[i+1];
    end

    srq_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ),
      .new_trk_i   (new_trk),
      .new_dist_i  (new_dist),
      .left_ge_i   (left_ge),
      .left_trk_i  (left_trk),
      .left_dist_i (left_dist),
      .right_trk_i (right_trk),
      .right_dist_i(right_dist),
      .ge_o        (ge[i]),
      .trk_o       (trk[i]),
      .dist_o      (seek_dist[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Build the result from the pre-step head cell and the post-step count.
  always_comb begin
    rsp_d               = '0;
    rsp_d.removed_valid = ctl.rem;
    rsp_d.removed_track = ctl.rem ? 16'(trk[0]) : '0;
    rsp_d.underflow     = accept && (req_i.action == ActRemove) && empty;
    rsp_d.dropped_full  = accept && (req_i.action == ActInsert) && full;
    rsp_d.is_empty      = (count_d == '0);
    rsp_d.entry_count   = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= 1'b0;
      count_q     <= count_d;
      rsp_valid_q <= accept;
    end
  end

  // Capture the result payload on each transfer; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o      = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Count never passes the chain length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  // Every transfer gives exactly one result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> rsp_valid_o)
    else $error("missing result after transfer");

  // An underflow result reports an empty queue and no popped entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.underflow |-> rsp_o.is_empty && !rsp_o.removed_valid)
    else $error("underflow with entries or pop");

  // The count only moves in response to a transfer, by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("count moved without transfer");

  // A dropped insert happens only with a full queue and leaves it full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.dropped_full |-> full && !rsp_o.is_empty)
    else $error("drop without full queue");

endmodule

// ===== src/srq_cell.sv =====
module srq_cell
  import srq_pkg::*;
#(
  parameter int unsigned TRACK_BITS = TrackBitsDefault
) (
  input  logic                  clk_i,
  input  srq_ctl_t              ctl_i,
  input  logic                  occ_i,
  input  logic [TRACK_BITS-1:0] new_trk_i,
  input  logic [TRACK_BITS-1:0] new_dist_i,
  input  logic                  left_ge_i,
  input  logic [TRACK_BITS-1:0] left_trk_i,
  input  logic [TRACK_BITS-1:0] left_dist_i,
  input  logic [TRACK_BITS-1:0] right_trk_i,
  input  logic [TRACK_BITS-1:0] right_dist_i,
  output logic                  ge_o,
  output logic [TRACK_BITS-1:0] trk_o,
  output logic [TRACK_BITS-1:0] dist_o
);

  logic [TRACK_BITS-1:0] trk_q, trk_d;
  logic [TRACK_BITS-1:0] dist_q, dist_d;

  // An empty cell counts as "at or after" the insert point.
  assign ge_o   = !occ_i || (dist_q >= new_dist_i);
  assign trk_o  = trk_q;
  assign dist_o = dist_q;

  always_comb begin
    trk_d  = trk_q;
    dist_d = dist_q;
    if (ctl_i.ins && ge_o) begin
      if (left_ge_i) begin
        // shift right: take the neighbor's entry
        trk_d  = left_trk_i;
        dist_d = left_dist_i;
      end else begin
        // first cell at or after the insert point: take the new entry
        trk_d  = new_trk_i;
        dist_d = new_dist_i;
      end
    end else if (ctl_i.rem) begin
      trk_d  = right_trk_i;
      dist_d = right_dist_i;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q  <= trk_d;
    dist_q <= dist_d;
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import srq_pkg::*;

  localparam int unsigned DEPTH       = DepthDefault;
  localparam int unsigned LIMIT_CYCLES = 100000;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Request side, driven by the stimulus tasks
  logic     start_i = 1'b0;
  srq_req_t req_i   = '0;

  // Result side
  logic     busy_o;
  logic     rsp_valid_o;
  srq_rsp_t rsp_o;

  sstf_request_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the queue contents: slot 0 holds the nearest request.
  logic [15:0] mirror_track [DEPTH];
  logic [15:0] mirror_dist  [DEPTH];
  int unsigned mirror_count = 0;

  // Results expected from the block, oldest first
  srq_rsp_t    pending_rsp [$];
  srq_rsp_t    want_rsp;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en   = 1'b1;

  // Apply one request transfer to the mirror and return the result it must produce.
  function automatic srq_rsp_t seek_queue_apply(input srq_req_t r);
    srq_rsp_t    rsp;
    logic [15:0] seek_dist;
    int          pos;
    int          i;
    rsp = '0;
    if (r.action == ActInsert) begin
      if (mirror_count >= DEPTH) begin
        rsp.dropped_full = 1'b1;
      end else begin
        seek_dist = (r.track >= r.head_position) ? r.track - r.head_position
                                                 : r.head_position - r.track;
        // Go ahead of the first entry that is not nearer: newest wins a tie.
        pos = mirror_count;
        for (i = 0; i < mirror_count; i++) begin
          if (mirror_dist[i] >= seek_dist) begin
            pos = i;
            break;
          end
        end
        for (i = mirror_count; i > pos; i--) begin
          mirror_track[i] = mirror_track[i-1];
          mirror_dist[i]  = mirror_dist[i-1];
        end
        mirror_track[pos] = r.track;
        mirror_dist[pos]  = seek_dist;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        rsp.underflow = 1'b1;
      end else begin
        rsp.removed_track = mirror_track[0];
        rsp.removed_valid = 1'b1;
        for (i = 1; i < mirror_count; i++) begin
          mirror_track[i-1] = mirror_track[i];
          mirror_dist[i-1]  = mirror_dist[i];
        end
        mirror_count--;
      end
    end
    rsp.is_empty    = (mirror_count == 0);
    rsp.entry_count = mirror_count[4:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_cnt, what, got, want);
  endtask

  // Monitor: sample at the rising edge so both sides see pre-edge values.
  // Record the expectation of a transfer before checking a result, which
  // keeps order even if a result came in the same cycle as its request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        pending_rsp.push_back(seek_queue_apply(req_i));
      if (rsp_valid_o) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result", rsp_o.entry_count, -1);
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (rsp_o.removed_track !== want_rsp.removed_track)
            report_mismatch("removed_track", rsp_o.removed_track, want_rsp.removed_track);
          if (rsp_o.removed_valid !== want_rsp.removed_valid)
            report_mismatch("removed_valid", rsp_o.removed_valid, want_rsp.removed_valid);
          if (rsp_o.underflow !== want_rsp.underflow)
            report_mismatch("underflow", rsp_o.underflow, want_rsp.underflow);
          if (rsp_o.dropped_full !== want_rsp.dropped_full)
            report_mismatch("dropped_full", rsp_o.dropped_full, want_rsp.dropped_full);
          if (rsp_o.is_empty !== want_rsp.is_empty)
            report_mismatch("is_empty", rsp_o.is_empty, want_rsp.is_empty);
          if (rsp_o.entry_count !== want_rsp.entry_count)
            report_mismatch("entry_count", rsp_o.entry_count, want_rsp.entry_count);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic srq_req_t make_req(input logic act, input logic [15:0] trk,
                                        input logic [15:0] hp);
    srq_req_t r;
    r.action        = act;
    r.track         = trk;
    r.head_position = hp;
    return r;
  endfunction

  // Random insert: close to the head (many equal distances), anywhere, or at the rails.
  function automatic srq_req_t rand_insert();
    int          pick;
    logic [15:0] base;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      base = 16'($urandom_range(0, 65535 - 15));
      return make_req(ActInsert, 16'(base + $urandom_range(0, 15)),
                      16'(base + $urandom_range(0, 15)));
    end else if (pick < 80) begin
      return make_req(ActInsert, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
    end
    return make_req(ActInsert,
                    ($urandom_range(0, 2) == 0) ? 16'h0000 :
                    ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)),
                    ($urandom_range(0, 2) == 0) ? 16'h0000 :
                    ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
  endfunction

  // Remove carries random track fields; the block must ignore them.
  function automatic srq_req_t rand_remove();
    return make_req(ActRemove, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
  endfunction

  // Present one request and hold it until the transfer. Leave start high on
  // return so a back-to-back request needs no second assignment this step.
  task automatic send_req(input srq_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for one cycle after about 19 of 100 transfers.
  task automatic maybe_idle();
    if (idle_en && $urandom_range(0, 99) < 19) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_and_idle(input srq_req_t r);
    send_req(r);
    maybe_idle();
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Remove from an empty queue right after reset must flag underflow.
  task automatic test_underflow_on_empty();
    send_and_idle(make_req(ActRemove, 16'hFFFF, 16'hFFFF));
  endtask

  // Zero and full-scale distances, in both directions of seek.
  task automatic test_distance_extremes();
    send_and_idle(make_req(ActInsert, 16'h0000, 16'h0000));
    send_and_idle(make_req(ActInsert, 16'hFFFF, 16'h0000));
    send_and_idle(make_req(ActInsert, 16'h0000, 16'hFFFF));
    send_and_idle(make_req(ActInsert, 16'hFFFF, 16'hFFFF));
    repeat (4) send_and_idle(make_req(ActRemove, 16'h0000, 16'h0000));
  endtask

  // Equal distances: the newest entry must be served first.
  task automatic test_equal_distance_order();
    send_and_idle(make_req(ActInsert, 16'd100, 16'd50));
    send_and_idle(make_req(ActInsert, 16'd0,   16'd50));
    send_and_idle(make_req(ActInsert, 16'd75,  16'd50));
    repeat (3) send_and_idle(rand_remove());
    send_and_idle(rand_remove());
  endtask

  // Fill past the top (drops), then drain past the bottom (underflows).
  task automatic test_full_queue_drops();
    repeat (8) begin
      repeat (DEPTH + $urandom_range(1, 3)) send_and_idle(rand_insert());
      repeat (DEPTH + $urandom_range(1, 3)) send_and_idle(rand_remove());
    end
  endtask

  // Mixed traffic at varying insert bias; a no-idle stretch in the middle.
  task automatic test_random_traffic();
    int bias;
    for (int seg = 0; seg < 10; seg++) begin
      bias    = (seg % 3 == 0) ? 75 : (seg % 3 == 1) ? 50 : 30;
      idle_en = !(seg >= 4 && seg <= 6);
      repeat (100) begin
        if ($urandom_range(0, 99) < bias) send_and_idle(rand_insert());
        else                              send_and_idle(rand_remove());
      end
      if (seg == 2 || seg == 7) wait_for_drain();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_underflow_on_empty();
    test_distance_extremes();
    test_equal_distance_order();
    test_full_queue_drops();
    test_random_traffic();

    // Wait out the last results, then wait on for any stray strobe.
    wait_for_drain();
    repeat (5) @(posedge clk_i);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
